FILE: rtl/kej_pkg.sv
// Shared types and constants for the key equi-join engine.
// Depends on nothing; every other file imports it.
package kej_pkg;

  localparam int MAIN_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(MAIN_DEPTH);
  localparam int COUNT_W    = $clog2(MAIN_DEPTH + 1);

  localparam int KEY_W = 32;
  localparam int IDX_W = 24;

  localparam int Q_DEPTH  = 2;
  localparam int Q_ADDR_W = $clog2(Q_DEPTH);
  localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PROBE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_MATCH  = 2'd2,
    ST_MISS   = 2'd3
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] ridx;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } entry_t;

endpackage

FILE: rtl/kej_in_if.sv
// Input channel of the join engine: valid/ready plus one load or probe item.
// Depends on kej_pkg.
interface kej_in_if
  import kej_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [KEY_W-1:0] join_key;
  logic [IDX_W-1:0] record_index;
  logic             last_probe;

  modport source (output valid, func, join_key, record_index, last_probe, input ready);
  modport sink   (input valid, func, join_key, record_index, last_probe, output ready);
endinterface

FILE: rtl/kej_out_if.sv
// Result channel of the join engine: valid/ready plus one result item.
// Depends on kej_pkg.
interface kej_out_if
  import kej_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] matched_index;
  logic [IDX_W-1:0] probe_index;
  logic             end_of_join;

  modport source (output valid, status, matched_index, probe_index, end_of_join, input ready);
  modport sink   (input valid, status, matched_index, probe_index, end_of_join, output ready);
endinterface

FILE: rtl/kej_front.sv
// Front stage: registers an input item, decodes it into a command, hands it to the queue.
// Depends on kej_pkg and kej_in_if.
module kej_front
  import kej_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kej_in_if.sink     items,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       push_ready
);

  logic held;
  cmd_t cmd;

  assign push        = held;
  assign push_cmd    = cmd;
  assign items.ready = !held || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (items.valid && items.ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
    if (items.valid && items.ready) begin
      cmd.op   <= items.func ? OP_PROBE : OP_LOAD;
      cmd.key  <= items.join_key;
      cmd.ridx <= items.record_index;
      // the end marker only means something on a probe
      cmd.last <= items.func & items.last_probe;
    end
  end

endmodule

FILE: rtl/kej_queue.sv
// Short command queue between the front stage and the table engine.
// Depends on kej_pkg.
module kej_queue
  import kej_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  cmd_t                slots [Q_DEPTH];
  logic [Q_ADDR_W-1:0] wr_ptr;
  logic [Q_ADDR_W-1:0] rd_ptr;
  logic [Q_FILL_W-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = fill != Q_FILL_W'(Q_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_ADDR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_ADDR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/kej_back.sv
// Table engine: sorted key table in one RAM, insertion by shifting, binary search probes.
// Depends on kej_pkg and kej_out_if.
module kej_back
  import kej_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  kej_out_if.source results
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAIN_DEPTH);

  state_t             state;
  logic [COUNT_W-1:0] count;
  cmd_t               cur;
  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] hi;
  logic [ADDR_W-1:0]  mid;
  logic               hi_eq;
  logic [IDX_W-1:0]   hi_idx;
  logic [ADDR_W-1:0]  pos;
  status_t            res_status;
  logic [IDX_W-1:0]   res_main;
  logic [IDX_W-1:0]   res_foreign;
  logic               res_end;

  entry_t             mem [MAIN_DEPTH];
  entry_t             rdata;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;

  entry_t             new_entry;
  logic               go_right;
  logic               hit;
  logic [COUNT_W-1:0] lo_next;
  logic [COUNT_W-1:0] hi_next;
  logic [COUNT_W-1:0] mid_next;
  logic               hi_eq_next;
  logic [IDX_W-1:0]   hi_idx_next;
  logic               move_up;
  logic               slot_free;

  assign new_entry  = '{key: cur.key, idx: cur.ridx};
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign slot_free  = !results.valid || results.ready;

  // one binary search step on the entry read last cycle
  assign go_right    = rdata.key < cur.key;
  assign hit         = rdata.key == cur.key;
  assign lo_next     = go_right ? COUNT_W'(mid) + 1'b1 : lo;
  assign hi_next     = go_right ? hi : COUNT_W'(mid);
  assign hi_eq_next  = go_right ? hi_eq : hit;
  assign hi_idx_next = go_right ? hi_idx : rdata.idx;
  assign mid_next    = lo_next + ((hi_next - lo_next) >> 1);

  // insertion: entries with a larger key move up one slot
  assign move_up = rdata.key > cur.key;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_entry;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_LOAD) begin
            if (count == '0) begin
              wr_en   = 1'b1;
              wr_data = '{key: cmd.key, idx: cmd.ridx};
            end else if (count != FULL_COUNT) begin
              rd_en   = 1'b1;
              rd_addr = ADDR_W'(count - 1'b1);
            end
          end else if (count != '0) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(count >> 1);
          end
        end
      end
      S_SEARCH: begin
        if (lo_next < hi_next) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(mid_next);
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos + 1'b1;
        if (move_up) begin
          wr_data = rdata;
          if (pos != '0) begin
            rd_en   = 1'b1;
            rd_addr = pos - 1'b1;
          end
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      results.valid <= 1'b0;
    end else begin
      // raise valid when a result is issued, drop it after its transfer
      if (state == S_DONE && slot_free) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur         <= cmd;
            res_main    <= '0;
            res_foreign <= (cmd.op == OP_PROBE) ? cmd.ridx : '0;
            res_end     <= cmd.last;
            if (cmd.op == OP_LOAD) begin
              if (count == FULL_COUNT) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if (count == '0) begin
                count      <= count + 1'b1;
                res_status <= ST_LOADED;
                state      <= S_DONE;
              end else begin
                pos   <= ADDR_W'(count - 1'b1);
                state <= S_SHIFT;
              end
            end else begin
              lo          <= '0;
              hi          <= count;
              hi_eq       <= 1'b0;
              mid         <= ADDR_W'(count >> 1);
              if (count == '0) begin
                res_status <= ST_MISS;
                state      <= S_DONE;
              end else begin
                state <= S_SEARCH;
              end
            end
          end
        end
        S_SEARCH: begin
          lo     <= lo_next;
          hi     <= hi_next;
          hi_eq  <= hi_eq_next;
          hi_idx <= hi_idx_next;
          mid    <= ADDR_W'(mid_next);
          if (lo_next >= hi_next) begin
            // the bound entry was read when hi last moved onto it
            res_status <= hi_eq_next ? ST_MATCH : ST_MISS;
            res_main   <= hi_eq_next ? hi_idx_next : '0;
            state      <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (move_up) begin
            if (pos == '0) begin
              state <= S_PLACE;
            end else begin
              pos <= pos - 1'b1;
            end
          end else begin
            count      <= count + 1'b1;
            res_status <= ST_LOADED;
            state      <= S_DONE;
          end
        end
        S_PLACE: begin
          count      <= count + 1'b1;
          res_status <= ST_LOADED;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (state == S_DONE && slot_free) begin
      results.status        <= res_status;
      results.matched_index <= res_main;
      results.probe_index   <= res_foreign;
      results.end_of_join   <= res_end;
    end
  end

endmodule

FILE: rtl/key_equi_join_engine_top.sv
// Top level of the key equi-join engine: front stage, command queue, table engine.
// Depends on kej_pkg, kej_in_if, kej_out_if, kej_front, kej_queue and kej_back.
//
//   Channel   Dir  Handshake     Payload
//   items     in   valid/ready   func, join_key, record_index, last_probe
//   results   out  valid/ready   status, matched_index, probe_index, end_of_join
//
// Flow: an item passes through the front register and the queue, then the table engine.
//   A probe runs a binary search, one RAM read per step. A load walks down from the
//   top entry, moving one larger key up per cycle.
// Reset: clears the entry count and all handshake state; the table RAM is not
//   cleared, since only entries below the count are ever read. No clearing pass.
// Stalls: the queue lets the front keep taking items while the engine works,
//   and the result register lets the engine finish while a result waits.
module key_equi_join_engine_top
  import kej_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  kej_in_if.sink      items,
  kej_out_if.source   results
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic push_ready;

  // queue to engine
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // classify and register each accepted item
  kej_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // decouple the front from the engine
  kej_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (cmd_valid),
    .pop_cmd    (cmd),
    .pop        (cmd_pop)
  );

  // sorted table, insert and search, result register
  kej_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .results   (results)
  );

endmodule
